/* rtl/otsu_pkg.sv */
// Package with the payload types, queue entry type and back-end state encoding.
package otsu_pkg;

  localparam int unsigned LumaW = 8;

  typedef struct packed {
    logic [7:0] red_level;
    logic [7:0] green_level;
    logic [7:0] blue_level;
    logic       frame_end;
  } pix_in_t;

  typedef struct packed {
    logic       is_dark;
    logic       frame_end_out;
    logic [7:0] threshold_used;
  } pix_out_t;

  typedef struct packed {
    logic [LumaW-1:0] luma;
    logic             is_dark;
    logic             frame_end;
    logic [LumaW-1:0] thr;
  } q_entry_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_PIX_UPD,
    BK_TOT_RD,
    BK_TOT_ACC,
    BK_SW_RD,
    BK_SW_ACC,
    BK_M_L,
    BK_M_R,
    BK_M_SQ,
    BK_M_D,
    BK_M_X1,
    BK_M_X2,
    BK_DONE
  } back_state_e;

endpackage

/* rtl/otsu_mul.sv */
// Shift-and-add serial multiplier, one multiplier bit per cycle.
module otsu_mul #(
  parameter int unsigned AW = 8,
  parameter int unsigned BW = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [AW-1:0]   a_i,
  input  logic [BW-1:0]   b_i,
  output logic            busy_o,
  output logic            done_o,
  output logic [AW+BW-1:0] prod_o
);
  localparam int unsigned PW   = AW + BW;
  localparam int unsigned CNTW = $clog2(BW + 1);

  logic [PW-1:0]   acc_q;
  logic [PW-1:0]   sh_q;
  logic [BW-1:0]   mb_q;
  logic [CNTW-1:0] cnt_q;
  logic            done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= CNTW'(BW);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - CNTW'(1);
        if (cnt_q == CNTW'(1)) begin
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= '0;
      sh_q  <= {{BW{1'b0}}, a_i};
      mb_q  <= b_i;
    end else if (cnt_q != '0) begin
      if (mb_q[0]) begin
        acc_q <= acc_q + sh_q;
      end
      sh_q <= sh_q << 1;
      mb_q <= mb_q >> 1;
    end
  end

  assign busy_o = (cnt_q != '0);
  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

/* rtl/otsu_fifo.sv */
// Two-entry queue between the pixel front end and the histogram back end.
module otsu_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  otsu_pkg::q_entry_t push_data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              empty_o,
  output otsu_pkg::q_entry_t head_o
);
  import otsu_pkg::*;

  q_entry_t   ent_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign head_o  = ent_q[rd_ptr_q];

endmodule

/* rtl/otsu_front.sv */
// Front end: accepts pixels, computes luma and classifies against the threshold.
module otsu_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  otsu_pkg::pix_in_t  in_data_i,
  input  logic [7:0]         thr_i,
  input  logic               sweep_done_i,
  input  logic               full_i,
  output logic               push_o,
  output otsu_pkg::q_entry_t push_data_o
);
  import otsu_pkg::*;

  logic        hold_q;
  logic [15:0] mix;
  logic [7:0]  luma;

  assign mix = 16'(in_data_i.red_level) * 16'd76
             + 16'(in_data_i.green_level) * 16'd150
             + 16'(in_data_i.blue_level) * 16'd30;
  assign luma = mix[15:8];

  assign in_stall_o = hold_q || full_i;
  assign push_o     = in_valid_i && !in_stall_o;

  assign push_data_o.luma      = luma;
  assign push_data_o.is_dark   = (luma < thr_i);
  assign push_data_o.frame_end = in_data_i.frame_end;
  assign push_data_o.thr       = thr_i;

  // A frame end holds the input until the new threshold is in place.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= 1'b0;
    end else if (sweep_done_i) begin
      hold_q <= 1'b0;
    end else if (push_o && in_data_i.frame_end) begin
      hold_q <= 1'b1;
    end
  end

endmodule

/* rtl/otsu_back.sv */
// Back end: histogram update, result register and the Otsu threshold sweep.
module otsu_back #(
  parameter int unsigned COUNT_BITS = 22
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               empty_i,
  input  otsu_pkg::q_entry_t head_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output otsu_pkg::pix_out_t out_data_o,
  output logic [7:0]         thr_o,
  output logic               sweep_done_o
);
  import otsu_pkg::*;

  localparam int unsigned CW   = COUNT_BITS;
  localparam int unsigned TW   = CW + 8;
  localparam int unsigned SW   = TW + 8;
  localparam int unsigned LW   = SW + TW;
  localparam int unsigned SQW  = 2 * LW;
  localparam int unsigned DW   = 2 * TW;
  localparam int unsigned PW   = SQW + LW;
  localparam int unsigned Bins = 256;

  back_state_e state_q, state_d;

  logic [CW-1:0]  hist_mem [Bins];
  logic [Bins-1:0] hist_vld_q;
  logic [CW-1:0]  rd_data_q;
  logic           rd_vld_q;
  logic [7:0]     rd_addr;
  logic           wr_en;
  logic [CW-1:0]  cnt_rd;
  logic [CW-1:0]  cnt_inc;

  q_entry_t       cur_q;
  logic           out_valid_q;
  pix_out_t       out_data_q;
  logic           out_free;
  logic           out_load;

  logic [7:0]     idx_q;
  logic [7:0]     thr_q;
  logic [7:0]     best_thr_q;
  logic [TW-1:0]  total_q, wb_q, wf_q;
  logic [SW-1:0]  sum_q, sb_q;
  logic [LW-1:0]  l_q;
  logic [SQW-1:0] sq_q, best_sq_q;
  logic [DW-1:0]  d_q, best_d_q;
  logic [PW-1:0]  x1_q;

  logic [CW+7:0]  ic;
  logic [TW-1:0]  wb_n, wf_n;
  logic [SW-1:0]  sb_n, sf;
  logic [LW-1:0]  prod_l, n_n;
  logic           last_bin;

  logic           mul_start, mul_busy, mul_done;
  logic [SQW-1:0] mul_a;
  logic [LW-1:0]  mul_b;
  logic [PW-1:0]  prod;

  otsu_mul #(.AW(SQW), .BW(LW)) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .busy_o  (mul_busy),
    .done_o  (mul_done),
    .prod_o  (prod)
  );

  assign cnt_rd   = rd_vld_q ? rd_data_q : '0;
  assign cnt_inc  = (cnt_rd == {CW{1'b1}}) ? cnt_rd : cnt_rd + CW'(1);
  assign ic       = {8'd0, cnt_rd} * {{CW{1'b0}}, idx_q};
  assign wb_n     = wb_q + TW'(cnt_rd);
  assign wf_n     = total_q - wb_n;
  assign sb_n     = sb_q + SW'(ic);
  assign sf       = sum_q - sb_q;
  assign prod_l   = prod[LW-1:0];
  assign n_n      = (l_q >= prod_l) ? (l_q - prod_l) : (prod_l - l_q);
  assign last_bin = (idx_q == 8'hFF);
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE:    if (!empty_i && out_free) state_d = BK_PIX_UPD;
      BK_PIX_UPD: state_d = cur_q.frame_end ? BK_TOT_RD : BK_IDLE;
      BK_TOT_RD:  state_d = BK_TOT_ACC;
      BK_TOT_ACC: state_d = last_bin ? BK_SW_RD : BK_TOT_RD;
      BK_SW_RD:   state_d = BK_SW_ACC;
      BK_SW_ACC: begin
        if (wb_n == '0) begin
          state_d = last_bin ? BK_DONE : BK_SW_RD;
        end else if (wf_n == '0) begin
          state_d = BK_DONE;
        end else begin
          state_d = BK_M_L;
        end
      end
      BK_M_L:     if (mul_done) state_d = BK_M_R;
      BK_M_R:     if (mul_done) state_d = BK_M_SQ;
      BK_M_SQ:    if (mul_done) state_d = BK_M_D;
      BK_M_D:     if (mul_done) state_d = BK_M_X1;
      BK_M_X1:    if (mul_done) state_d = BK_M_X2;
      BK_M_X2:    if (mul_done) state_d = last_bin ? BK_DONE : BK_SW_RD;
      BK_DONE:    state_d = BK_IDLE;
      default:    state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    pop_o     = 1'b0;
    rd_addr   = idx_q;
    wr_en     = 1'b0;
    out_load  = 1'b0;
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    unique case (state_q)
      BK_IDLE: begin
        rd_addr = head_i.luma;
        pop_o   = !empty_i && out_free;
      end
      BK_PIX_UPD: begin
        wr_en    = 1'b1;
        out_load = 1'b1;
      end
      BK_SW_ACC: begin
        mul_start = (wb_n != '0) && (wf_n != '0);
        mul_a     = SQW'(sb_n);
        mul_b     = LW'(wf_n);
      end
      BK_M_L: begin
        mul_start = mul_done;
        mul_a     = SQW'(sf);
        mul_b     = LW'(wb_q);
      end
      BK_M_R: begin
        mul_start = mul_done;
        mul_a     = SQW'(n_n);
        mul_b     = n_n;
      end
      BK_M_SQ: begin
        mul_start = mul_done;
        mul_a     = SQW'(wb_q);
        mul_b     = LW'(wf_q);
      end
      BK_M_D: begin
        mul_start = mul_done;
        mul_a     = sq_q;
        mul_b     = LW'(best_d_q);
      end
      BK_M_X1: begin
        mul_start = mul_done;
        mul_a     = best_sq_q;
        mul_b     = LW'(d_q);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= hist_mem[rd_addr];
    rd_vld_q  <= hist_vld_q[rd_addr];
    if (wr_en) begin
      hist_mem[cur_q.luma] <= cnt_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      hist_vld_q  <= '0;
      out_valid_q <= 1'b0;
      thr_q       <= '0;
    end else begin
      state_q <= state_d;
      if (wr_en) begin
        hist_vld_q[cur_q.luma] <= 1'b1;
      end else if (state_q == BK_DONE) begin
        hist_vld_q <= '0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == BK_DONE) begin
        thr_q <= best_thr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= head_i;
    end
    if (out_load) begin
      out_data_q.is_dark        <= cur_q.is_dark;
      out_data_q.frame_end_out  <= cur_q.frame_end;
      out_data_q.threshold_used <= cur_q.thr;
    end
    case (state_q)
      BK_PIX_UPD: begin
        idx_q   <= '0;
        total_q <= '0;
        sum_q   <= '0;
      end
      BK_TOT_ACC: begin
        total_q <= total_q + TW'(cnt_rd);
        sum_q   <= sum_q + SW'(ic);
        idx_q   <= idx_q + 8'd1;
        wb_q       <= '0;
        sb_q       <= '0;
        best_sq_q  <= '0;
        best_d_q   <= DW'(1);
        best_thr_q <= '0;
      end
      BK_SW_ACC: begin
        if (wb_n == '0) begin
          idx_q <= idx_q + 8'd1;
        end else begin
          wb_q <= wb_n;
          wf_q <= wf_n;
          sb_q <= sb_n;
        end
      end
      BK_M_L:  if (mul_done) l_q  <= prod_l;
      BK_M_SQ: if (mul_done) sq_q <= prod[SQW-1:0];
      BK_M_D:  if (mul_done) d_q  <= prod[DW-1:0];
      BK_M_X1: if (mul_done) x1_q <= prod;
      BK_M_X2: begin
        if (mul_done) begin
          if (x1_q > prod) begin
            best_sq_q  <= sq_q;
            best_d_q   <= d_q;
            best_thr_q <= idx_q;
          end
          idx_q <= idx_q + 8'd1;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o  = out_valid_q;
  assign out_data_o   = out_data_q;
  assign thr_o        = thr_q;
  assign sweep_done_o = (state_q == BK_DONE);

  a_mul_idle_on_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_start |-> !mul_busy) else $error("multiplier started while busy");

  a_out_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || !out_stall_i))
    else $error("result register overwritten while stalled");

  a_hist_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sweep_done_o |=> (hist_vld_q == '0)) else $error("histogram not cleared after sweep");

endmodule

/* rtl/otsu_binarize_video.sv */
// Top level of the Otsu binarisation block for an RGB24 pixel stream.
// Each pixel transfer is classified against the current threshold and counted into a
// 256-bin luma histogram; the back end reads the bin in its idle state and writes it back
// in the update state, one pixel at a time. After a pixel marked frame end, the input
// stalls while the sweep runs: a totals pass over all bins, a skip over leading empty bins,
// and for every candidate bin a chain of products on the shared serial multiplier,
// after which the histogram is cleared in the done state and the new threshold applies.
module otsu_binarize_video #(
  parameter int unsigned COUNT_BITS = 22
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  otsu_pkg::pix_in_t in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output otsu_pkg::pix_out_t out_data_o
);
  import otsu_pkg::*;

  logic       push, full, pop, empty, sweep_done;
  logic [7:0] thr;
  q_entry_t   push_data, head;

  otsu_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .thr_i        (thr),
    .sweep_done_i (sweep_done),
    .full_i       (full),
    .push_o       (push),
    .push_data_o  (push_data)
  );

  otsu_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .head_o      (head)
  );

  otsu_back #(.COUNT_BITS(COUNT_BITS)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .empty_i      (empty),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o),
    .thr_o        (thr),
    .sweep_done_o (sweep_done)
  );

endmodule
